// File: rtl/core/pcg32_pkg.sv
// Shared types and constants for the PCG32 XSH-RR generator.
// Used by pcg32_lcg_step, pcg32_serial_mod and pcg32_random_generator.
// No dependencies.
package pcg32_pkg;

   localparam logic [63:0] LCG_MULT        = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC_DEFAULT = 64'd1442695040888963407;
   localparam logic [62:0] STREAM_RESET    = 63'd721347520444481703;

   // xorshift and rotate positions of the output function
   localparam int unsigned XS_SHIFT  = 18;
   localparam int unsigned XS_OUT    = 27;
   localparam int unsigned ROT_SHIFT = 59;

   localparam int unsigned FRAC_SHIFT = 8;

   typedef enum logic [2:0] {
      OP_RESEED   = 3'd0,
      OP_DRAW32   = 3'd1,
      OP_DRAW64   = 3'd2,
      OP_BOUNDED  = 3'd3,
      OP_FRACTION = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_SEED   = 2'd0,
      CSR_STREAM = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_BOOT_RUN,
      ST_IDLE,
      ST_RESEED,
      ST_DRAW,
      ST_THRESH,
      ST_REM,
      ST_DONE
   } fsm_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: rtl/core/pcg32_random_generator.sv
// Top level of the PCG32 XSH-RR generator: sequencer, state and output register.
// Depends on pcg32_pkg, pcg32_lcg_step and pcg32_serial_mod.
//
//  channel | ports   | fields (lowest bit first)
//  --------+---------+-----------------------------------------------
//  request | req_*   | tuser: opcode; tdata: low_bound, high_bound
//  result  | rsp_*   | tdata: raw_value, bounded_value
//  config  | csr_*   | index 0 seed_value, index 1 stream_select
//
// Every LCG step runs on a bit-serial multiplier. draw32, fraction and reseed wait for
// one step; draw64 draws its upper word with one step and then its lower word with another.
// Bounded integers below the full 32-bit range add two serial modulo passes plus a step per
// redraw; high_bound not above low_bound or an unused opcode goes to the result at once.
// After reset one LCG step seeds the state; req_tready stays low until then.
// A finished item waits in the output register while the next item is worked on.
module pcg32_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // low_bound[31:0], high_bound[63:32]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // raw_value[63:0], bounded_value[95:64]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import pcg32_pkg::*;

   fsm_type fsm_ff, fsm_in;

   logic [63:0] seed_ff;
   logic [62:0] stream_ff;
   logic [63:0] lcg_ff;
   logic [63:0] incr_ff;
   op_type      op_ff;
   logic [31:0] low_ff;
   logic [31:0] range_ff;
   logic [31:0] thr_ff;
   logic [31:0] upper_ff;
   logic        second_ff;
   logic [63:0] res_raw_ff;
   logic [31:0] res_bnd_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_raw_ff;
   logic [31:0] rsp_bnd_ff;

   logic        req_accept;
   op_type      req_op;
   logic [31:0] req_low;
   logic [31:0] req_high;
   logic [31:0] req_range;
   logic [63:0] new_incr;

   logic            step_start;
   logic [63:0]     step_state;
   logic [63:0]     step_incr;
   unit_status_type step_stat;
   logic [63:0]     step_next;
   logic [31:0]     step_draw;

   logic            mod_start;
   logic [31:0]     mod_dvd;
   logic [31:0]     mod_dsr;
   unit_status_type mod_stat;
   logic [31:0]     mod_rem;

   logic        incr_we;
   logic        thr_we;
   logic        upper_we;
   logic        res_we;
   logic [63:0] res_raw_in;
   logic [31:0] res_bnd_in;
   logic        out_we;

   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_low    = req_tdata[31:0];
   assign req_high   = req_tdata[63:32];
   assign req_range  = req_high - req_low + 32'd1;
   assign new_incr   = {stream_ff, 1'b1};
   assign req_tready = (fsm_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   pcg32_lcg_step u_step (
      .clock      (clock),
      .reset      (reset),
      .start      (step_start),
      .state_in   (step_state),
      .incr_in    (step_incr),
      .status     (step_stat),
      .next_state (step_next),
      .draw       (step_draw)
   );

   pcg32_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (mod_dsr),
      .status    (mod_stat),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= ST_BOOT;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_comb begin
      fsm_in     = fsm_ff;
      step_start = 1'b0;
      step_state = step_stat.done ? step_next : lcg_ff;
      step_incr  = incr_ff;
      mod_start  = 1'b0;
      mod_dvd    = step_draw;
      mod_dsr    = range_ff;
      incr_we    = 1'b0;
      thr_we     = 1'b0;
      upper_we   = 1'b0;
      res_we     = 1'b0;
      res_raw_in = '0;
      res_bnd_in = '0;
      out_we     = 1'b0;
      case (fsm_ff)
         ST_BOOT: begin
            // seed 0 from the zero state: the first step lands on the increment
            step_start = 1'b1;
            step_state = LCG_INC_DEFAULT;
            step_incr  = LCG_INC_DEFAULT;
            fsm_in     = ST_BOOT_RUN;
         end
         ST_BOOT_RUN: begin
            if (step_stat.done) begin
               fsm_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_RESEED: begin
                     step_start = 1'b1;
                     step_state = new_incr + seed_ff;
                     step_incr  = new_incr;
                     incr_we    = 1'b1;
                     fsm_in     = ST_RESEED;
                  end
                  OP_DRAW32, OP_DRAW64, OP_FRACTION: begin
                     step_start = 1'b1;
                     fsm_in     = ST_DRAW;
                  end
                  OP_BOUNDED: begin
                     if ($signed(req_low) >= $signed(req_high)) begin
                        res_we     = 1'b1;
                        res_bnd_in = req_low;
                        fsm_in     = ST_DONE;
                     end else if (req_range == 32'd0) begin
                        step_start = 1'b1;
                        fsm_in     = ST_DRAW;
                     end else begin
                        // range_ff is still loading: take the range straight from the item
                        mod_start = 1'b1;
                        mod_dvd   = 32'd0 - req_range;
                        mod_dsr   = req_range;
                        fsm_in    = ST_THRESH;
                     end
                  end
                  default: begin
                     res_we = 1'b1;
                     fsm_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RESEED: begin
            if (step_stat.done) begin
               res_we = 1'b1;
               fsm_in = ST_DONE;
            end
         end
         ST_THRESH: begin
            if (mod_stat.done) begin
               thr_we     = 1'b1;
               step_start = 1'b1;
               fsm_in     = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (step_stat.done) begin
               case (op_ff)
                  OP_DRAW32: begin
                     res_we     = 1'b1;
                     res_raw_in = {32'd0, step_draw};
                     fsm_in     = ST_DONE;
                  end
                  OP_FRACTION: begin
                     res_we     = 1'b1;
                     res_raw_in = {32'd0, step_draw >> FRAC_SHIFT};
                     fsm_in     = ST_DONE;
                  end
                  OP_DRAW64: begin
                     if (!second_ff) begin
                        upper_we   = 1'b1;
                        step_start = 1'b1;
                     end else begin
                        res_we     = 1'b1;
                        res_raw_in = {upper_ff, step_draw};
                        fsm_in     = ST_DONE;
                     end
                  end
                  OP_BOUNDED: begin
                     if (range_ff == 32'd0) begin
                        res_we     = 1'b1;
                        res_bnd_in = low_ff + step_draw;
                        fsm_in     = ST_DONE;
                     end else if (step_draw < thr_ff) begin
                        // reject and draw again
                        step_start = 1'b1;
                     end else begin
                        mod_start = 1'b1;
                        fsm_in    = ST_REM;
                     end
                  end
                  default: begin
                     res_we = 1'b1;
                     fsm_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_REM: begin
            if (mod_stat.done) begin
               res_we     = 1'b1;
               res_bnd_in = low_ff + mod_rem;
               fsm_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_we = 1'b1;
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         stream_ff <= STREAM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SEED:   seed_ff   <= csr_wdata;
            CSR_STREAM: stream_ff <= csr_wdata[62:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         incr_ff   <= LCG_INC_DEFAULT;
         second_ff <= 1'b0;
      end else begin
         if (incr_we) begin
            incr_ff <= new_incr;
         end
         if (req_accept) begin
            second_ff <= 1'b0;
         end else if (upper_we) begin
            second_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_stat.done) begin
         lcg_ff <= step_next;
      end
      if (req_accept) begin
         op_ff    <= req_op;
         low_ff   <= req_low;
         range_ff <= req_range;
      end
      if (thr_we) begin
         thr_ff <= mod_rem;
      end
      if (upper_we) begin
         upper_ff <= step_draw;
      end
      if (res_we) begin
         res_raw_ff <= res_raw_in;
         res_bnd_ff <= res_bnd_in;
      end
      if (out_we) begin
         rsp_raw_ff <= res_raw_ff;
         rsp_bnd_ff <= res_bnd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_we) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_bnd_ff, rsp_raw_ff};

`ifndef SYNTHESIS
   a_step_done_owned: assert property (@(posedge clock) disable iff (reset)
      step_stat.done |-> (fsm_ff == ST_BOOT_RUN || fsm_ff == ST_RESEED || fsm_ff == ST_DRAW))
      else $error("lcg step finished outside a drawing state");

   a_mod_done_owned: assert property (@(posedge clock) disable iff (reset)
      mod_stat.done |-> (fsm_ff == ST_THRESH || fsm_ff == ST_REM))
      else $error("modulo unit finished outside a bounded state");

   a_units_free_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!step_stat.busy && !mod_stat.busy))
      else $error("item accepted while a unit is still working");

   a_rem_nonzero_range: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_REM || fsm_ff == ST_THRESH) |-> (range_ff != 32'd0))
      else $error("modulo started with a zero range");

   a_out_load_on_done: assert property (@(posedge clock) disable iff (reset)
      out_we |=> (rsp_valid_ff && fsm_ff == ST_IDLE))
      else $error("result register not loaded when the item completed");
`endif

endmodule

// File: rtl/core/pcg32_lcg_step.sv
// One LCG step, state * LCG_MULT + increment, by a bit-serial shift-and-add
// multiplier, plus the XSH-RR draw of the old state. Depends on pcg32_pkg.
module pcg32_lcg_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                state_in,
   input  logic [63:0]                incr_in,
   output pcg32_pkg::unit_status_type status,
   output logic [63:0]                next_state,
   output logic [31:0]                draw
);
   import pcg32_pkg::*;

   logic        run_ff;
   logic        done_ff;
   logic [63:0] acc_ff;
   logic [63:0] mcand_ff;
   logic [63:0] mult_ff;
   logic [31:0] draw_ff;

   logic [63:0] xorred;
   logic [63:0] xs_wide;
   logic [31:0] xs;
   logic [4:0]  rot;
   logic [63:0] rotated;
   logic [31:0] draw_in;

   always_comb begin
      xorred  = (state_in >> XS_SHIFT) ^ state_in;
      xs_wide = xorred >> XS_OUT;
      xs      = xs_wide[31:0];
      rot     = state_in[ROT_SHIFT +: 5];
      rotated = {xs, xs} >> rot;
      draw_in = rotated[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (mult_ff[63:1] == 63'd0)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // one multiplier bit per cycle: add the shifted state where the bit is set
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= incr_in;
         mcand_ff <= state_in;
         mult_ff  <= LCG_MULT;
         draw_ff  <= draw_in;
      end else if (run_ff) begin
         if (mult_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff <= {mcand_ff[62:0], 1'b0};
         mult_ff  <= {1'b0, mult_ff[63:1]};
      end
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign next_state  = acc_ff;
   assign draw        = draw_ff;

endmodule

// File: rtl/core/pcg32_serial_mod.sv
// 32-bit remainder by restoring division, one dividend bit per cycle.
// Depends on pcg32_pkg.
module pcg32_serial_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [31:0]                divisor,
   output pcg32_pkg::unit_status_type status,
   output logic [31:0]                remainder
);
   import pcg32_pkg::*;

   logic        run_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvd_ff;
   logic [31:0] dsr_ff;

   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[31]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         // keep the difference where the divisor fits, else restore
         rem_ff <= diff[32] ? trial[31:0] : diff[31:0];
         dvd_ff <= {dvd_ff[30:0], 1'b0};
      end
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule
